>>> sv/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and constants for the banker's-algorithm resource allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int MAX_PROCS   = 8;
    localparam int MAX_RES     = 4;
    localparam int AMOUNT_BITS = 16;
    localparam int PROC_BITS   = 3;
    localparam int RES_BITS    = 2;
    // work vector holds available plus every allocation: 9 x 16-bit values
    localparam int WORK_BITS   = AMOUNT_BITS + 4;

    localparam logic REG_NUM_PROCS = 1'b0;
    localparam logic REG_NUM_RES   = 1'b1;

    typedef logic [AMOUNT_BITS-1:0] amount_t;
    typedef amount_t [MAX_RES-1:0] vec_t;

    typedef struct packed {
        logic [PROC_BITS-1:0] proc;
        vec_t                 vec;
    } qent_t;

    typedef enum logic [2:0] {
        KIND_TOTAL   = 3'd0,
        KIND_MAX     = 3'd1,
        KIND_ALLOC   = 3'd2,
        KIND_REQUEST = 3'd3,
        KIND_RELEASE = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        STS_GRANTED     = 3'd0,
        STS_EXCEEDS     = 3'd1,
        STS_QUEUED      = 3'd2,
        STS_DROPPED     = 3'd3,
        STS_RELEASED    = 3'd4,
        STS_REL_INVALID = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REQ_CHK,
        S_REL_CHK,
        S_SAFE_INIT,
        S_SAFE_STEP,
        S_GRANT,
        S_ENQ,
        S_SCAN_RD,
        S_SCAN_LOAD,
        S_SCAN_CHK,
        S_SCAN_KEEP,
        S_REPORT
    } state_t;

    typedef enum logic [1:0] {
        ROW_IN,
        ROW_CAND,
        ROW_SAFE
    } row_sel_t;

    typedef struct packed {
        logic     load_op;
        logic     pend_wr;
        logic     cmd_start;
        row_sel_t row_sel;
        logic     rel_apply;
        logic     safe_init;
        logic     safe_step;
        logic     grant;
        logic     enq;
        logic     scan_init;
        logic     q_rd;
        logic     cand_from_q;
        logic     keep;
        logic     scan_grant;
        logic     scan_fin;
        logic     set_status;
        status_t  status_code;
        logic     rep_load;
    } cmd_t;

    typedef struct packed {
        logic req_ok;
        logic afford;
        logic rel_ok;
        logic safe_fin;
        logic safe_ok;
        logic q_full;
        logic scan_end;
        logic out_free;
        logic rep_last;
    } sts_t;

endpackage

>>> sv/bra_dpath.sv
// ----------------------------------------------------------------------------
// bra_dpath
// Tables, available vector, safety walker, wait queue and result register.
// ----------------------------------------------------------------------------
module bra_dpath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bra_pkg::cmd_t                 cmd,
    output bra_pkg::sts_t                 sts,
    input  logic [2:0]                    s_kind,
    input  logic [bra_pkg::PROC_BITS-1:0] s_process,
    input  logic [bra_pkg::RES_BITS-1:0]  s_resource,
    input  bra_pkg::amount_t              s_amount,
    input  logic [3:0]                    num_procs,
    input  logic [2:0]                    num_res,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [bra_pkg::RES_BITS-1:0]  m_res_idx,
    output bra_pkg::amount_t              m_avail,
    output logic [2:0]                    m_status,
    output logic [4:0]                    m_granted,
    output logic                          m_last
);
    import bra_pkg::*;

    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    vec_t                 max_reg   [MAX_PROCS];
    vec_t                 alloc_reg [MAX_PROCS];
    vec_t                 alloc_next[MAX_PROCS];
    vec_t                 avail_reg, avail_next;
    vec_t                 pend_reg, pend_next;
    vec_t                 pend_merged;
    logic [PROC_BITS-1:0] cand_proc_reg, cand_proc_next;
    vec_t                 cand_vec_reg, cand_vec_next;

    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        scan_i_reg, scan_i_next;
    logic [CW-1:0]        keep_reg, keep_next;
    logic [CW-1:0]        gcnt_reg, gcnt_next;
    status_t              status_reg, status_next;
    logic [RES_BITS-1:0]  rep_j_reg, rep_j_next;

    logic [WORK_BITS-1:0] work_reg[MAX_RES];
    logic [WORK_BITS-1:0] work_next[MAX_RES];
    logic [MAX_PROCS-1:0] done_reg, done_next;
    logic [PROC_BITS-1:0] safe_i_reg, safe_i_next;
    logic [PROC_BITS:0]   fin_reg, fin_next;
    logic                 prog_reg, prog_next;

    qent_t                q_mem[QUEUE_DEPTH];
    qent_t                q_rd_reg;
    logic                 q_we;
    logic [QIW-1:0]       q_waddr;

    logic                 m_valid_reg, m_valid_next;
    logic [RES_BITS-1:0]  m_res_reg;
    amount_t              m_avail_reg;
    logic [2:0]           m_status_reg;
    logic [4:0]           m_gfq_reg;
    logic                 m_last_reg;

    logic [PROC_BITS-1:0] row_addr;
    vec_t                 max_row, alloc_row;
    logic [MAX_RES-1:0]   en;
    logic                 proc_ok;
    logic                 req_ok, afford, rel_ok;
    logic [AMOUNT_BITS:0] al[MAX_RES];
    logic                 step_ok;
    logic [PROC_BITS:0]   fin_step;
    logic                 pass_end;
    logic signed [AMOUNT_BITS+1:0] ld_sum;
    logic [AMOUNT_BITS:0] rel_sum;
    logic [4:0]           gfq;

    always_comb begin
        case (cmd.row_sel)
            ROW_IN:   row_addr = s_process;
            ROW_CAND: row_addr = cand_proc_reg;
            ROW_SAFE: row_addr = safe_i_reg;
            default:  row_addr = cand_proc_reg;
        endcase
    end

    assign max_row   = max_reg[row_addr];
    assign alloc_row = alloc_reg[row_addr];
    assign proc_ok   = ({1'b0, cand_proc_reg} < num_procs);

    // admission checks over the resources in use
    always_comb begin
        req_ok = proc_ok;
        afford = 1'b1;
        rel_ok = proc_ok;
        for (int j = 0; j < MAX_RES; j++) begin
            en[j] = (j < int'(num_res));
            if (en[j]) begin
                if (({1'b0, alloc_row[j]} + {1'b0, cand_vec_reg[j]}) > {1'b0, max_row[j]})
                    req_ok = 1'b0;
                if (cand_vec_reg[j] > avail_reg[j])
                    afford = 1'b0;
                if (cand_vec_reg[j] > alloc_row[j])
                    rel_ok = 1'b0;
            end
        end
    end

    // one process of the safety sequence per cycle
    always_comb begin
        step_ok = ~done_reg[safe_i_reg];
        for (int j = 0; j < MAX_RES; j++) begin
            al[j] = {1'b0, alloc_row[j]}
                  + ((safe_i_reg == cand_proc_reg) ? {1'b0, cand_vec_reg[j]} : '0);
            if (en[j] && ({{(WORK_BITS-AMOUNT_BITS){1'b0}}, max_row[j]} >
                          ({{(WORK_BITS-AMOUNT_BITS-1){1'b0}}, al[j]} + work_reg[j])))
                step_ok = 1'b0;
        end
        fin_step = fin_reg + {{PROC_BITS{1'b0}}, step_ok};
        pass_end = ({1'b0, safe_i_reg} + 4'(1)) == num_procs;
    end

    always_comb begin
        pend_merged = pend_reg;
        pend_merged[s_resource] = s_amount;
    end

    assign gfq = (32'(gcnt_reg) > 32'd31) ? 5'd31 : 5'(gcnt_reg);

    always_comb begin
        avail_next     = avail_reg;
        pend_next      = pend_reg;
        cand_proc_next = cand_proc_reg;
        cand_vec_next  = cand_vec_reg;
        count_next     = count_reg;
        scan_i_next    = scan_i_reg;
        keep_next      = keep_reg;
        gcnt_next      = gcnt_reg;
        status_next    = status_reg;
        rep_j_next     = rep_j_reg;
        done_next      = done_reg;
        safe_i_next    = safe_i_reg;
        fin_next       = fin_reg;
        prog_next      = prog_reg;
        ld_sum         = '0;
        rel_sum        = '0;
        q_we           = 1'b0;
        q_waddr        = keep_reg[QIW-1:0];
        for (int p = 0; p < MAX_PROCS; p++) alloc_next[p] = alloc_reg[p];
        for (int j = 0; j < MAX_RES; j++) work_next[j] = work_reg[j];

        if (cmd.load_op) begin
            case (s_kind)
                KIND_TOTAL: avail_next[s_resource] = s_amount;
                KIND_ALLOC: begin
                    ld_sum = $signed({2'b00, avail_reg[s_resource]})
                           + $signed({2'b00, alloc_row[s_resource]})
                           - $signed({2'b00, s_amount});
                    if (ld_sum < 0)
                        avail_next[s_resource] = '0;
                    else if (ld_sum > $signed({2'b00, {AMOUNT_BITS{1'b1}}}))
                        avail_next[s_resource] = '1;
                    else
                        avail_next[s_resource] = ld_sum[AMOUNT_BITS-1:0];
                    alloc_next[s_process][s_resource] = s_amount;
                end
                default: ;
            endcase
        end

        if (cmd.pend_wr) begin
            if (cmd.cmd_start) begin
                cand_vec_next  = pend_merged;
                cand_proc_next = s_process;
                pend_next      = '0;
                gcnt_next      = '0;
                rep_j_next     = '0;
            end else begin
                pend_next = pend_merged;
            end
        end

        if (cmd.rel_apply) begin
            for (int j = 0; j < MAX_RES; j++) begin
                if (en[j]) begin
                    rel_sum = {1'b0, avail_reg[j]} + {1'b0, cand_vec_reg[j]};
                    avail_next[j] = rel_sum[AMOUNT_BITS] ? '1 : rel_sum[AMOUNT_BITS-1:0];
                    alloc_next[cand_proc_reg][j] = alloc_row[j] - cand_vec_reg[j];
                end
            end
        end

        if (cmd.grant) begin
            for (int j = 0; j < MAX_RES; j++) begin
                if (en[j]) begin
                    avail_next[j] = avail_reg[j] - cand_vec_reg[j];
                    alloc_next[cand_proc_reg][j] = alloc_row[j] + cand_vec_reg[j];
                end
            end
        end

        if (cmd.safe_init) begin
            for (int j = 0; j < MAX_RES; j++)
                work_next[j] = en[j]
                    ? WORK_BITS'(avail_reg[j] - cand_vec_reg[j]) : '0;
            done_next   = '0;
            safe_i_next = '0;
            fin_next    = '0;
            prog_next   = 1'b0;
        end

        if (cmd.safe_step) begin
            if (step_ok) begin
                for (int j = 0; j < MAX_RES; j++)
                    work_next[j] = work_reg[j]
                        + {{(WORK_BITS-AMOUNT_BITS-1){1'b0}}, al[j]};
                done_next[safe_i_reg] = 1'b1;
            end
            fin_next = fin_step;
            if (pass_end) begin
                safe_i_next = '0;
                prog_next   = 1'b0;
            end else begin
                safe_i_next = safe_i_reg + 1'b1;
                prog_next   = prog_reg | step_ok;
            end
        end

        if (cmd.enq) begin
            q_we       = 1'b1;
            q_waddr    = count_reg[QIW-1:0];
            count_next = count_reg + 1'b1;
        end

        if (cmd.scan_init) begin
            scan_i_next = '0;
            keep_next   = '0;
        end

        if (cmd.cand_from_q) begin
            cand_proc_next = q_rd_reg.proc;
            cand_vec_next  = q_rd_reg.vec;
        end

        if (cmd.keep) begin
            q_we        = 1'b1;
            keep_next   = keep_reg + 1'b1;
            scan_i_next = scan_i_reg + 1'b1;
        end

        if (cmd.scan_grant) begin
            gcnt_next   = gcnt_reg + 1'b1;
            scan_i_next = scan_i_reg + 1'b1;
        end

        if (cmd.scan_fin)
            count_next = keep_reg;

        if (cmd.set_status)
            status_next = cmd.status_code;

        if (cmd.rep_load)
            rep_j_next = rep_j_reg + 1'b1;
    end

    assign m_valid_next = cmd.rep_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < MAX_PROCS; p++) begin
                max_reg[p]   <= '0;
                alloc_reg[p] <= '0;
            end
            avail_reg   <= '0;
            pend_reg    <= '0;
            count_reg   <= '0;
            scan_i_reg  <= '0;
            keep_reg    <= '0;
            gcnt_reg    <= '0;
            status_reg  <= STS_GRANTED;
            rep_j_reg   <= '0;
            done_reg    <= '0;
            safe_i_reg  <= '0;
            fin_reg     <= '0;
            prog_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int p = 0; p < MAX_PROCS; p++) alloc_reg[p] <= alloc_next[p];
            if (cmd.load_op && (s_kind == KIND_MAX))
                max_reg[s_process][s_resource] <= s_amount;
            avail_reg   <= avail_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            scan_i_reg  <= scan_i_next;
            keep_reg    <= keep_next;
            gcnt_reg    <= gcnt_next;
            status_reg  <= status_next;
            rep_j_reg   <= rep_j_next;
            done_reg    <= done_next;
            safe_i_reg  <= safe_i_next;
            fin_reg     <= fin_next;
            prog_reg    <= prog_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cand_proc_reg <= cand_proc_next;
        cand_vec_reg  <= cand_vec_next;
        for (int j = 0; j < MAX_RES; j++) work_reg[j] <= work_next[j];
        if (cmd.rep_load) begin
            m_res_reg    <= rep_j_reg;
            m_avail_reg  <= avail_reg[rep_j_reg];
            m_status_reg <= status_reg;
            m_gfq_reg    <= gfq;
            m_last_reg   <= sts.rep_last;
        end
    end

    // wait queue memory
    always_ff @(posedge aclk) begin
        if (q_we)
            q_mem[q_waddr] <= '{proc: cand_proc_reg, vec: cand_vec_reg};
        if (cmd.q_rd)
            q_rd_reg <= q_mem[scan_i_reg[QIW-1:0]];
    end

    always_comb begin
        sts.req_ok   = req_ok;
        sts.afford   = afford;
        sts.rel_ok   = rel_ok;
        sts.safe_fin = (fin_step == num_procs) || (pass_end && !(prog_reg || step_ok));
        sts.safe_ok  = (fin_step == num_procs);
        sts.q_full   = (count_reg == CW'(QUEUE_DEPTH));
        sts.scan_end = (scan_i_reg >= count_reg);
        sts.out_free = !m_valid_reg || m_tready;
        sts.rep_last = ({1'b0, rep_j_reg} + 3'(1)) == num_res;
    end

    assign m_tvalid  = m_valid_reg;
    assign m_res_idx = m_res_reg;
    assign m_avail   = m_avail_reg;
    assign m_status  = m_status_reg;
    assign m_granted = m_gfq_reg;
    assign m_last    = m_last_reg;

endmodule

>>> sv/bra_ctrl.sv
// ----------------------------------------------------------------------------
// bra_ctrl
// Command sequencer: admission, safety walk, enqueue, rescan and report.
// ----------------------------------------------------------------------------
module bra_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [2:0]    s_kind,
    input  logic          s_last,
    input  bra_pkg::sts_t sts,
    output bra_pkg::cmd_t cmd
);
    import bra_pkg::*;

    state_t state_reg, state_next;
    logic   scan_ctx_reg, scan_ctx_next;
    logic   vec_kind;

    assign vec_kind = (s_kind == KIND_REQUEST) || (s_kind == KIND_RELEASE);

    always_comb begin
        state_next    = state_reg;
        scan_ctx_next = scan_ctx_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && vec_kind && s_last) begin
                    scan_ctx_next = 1'b0;
                    state_next = (s_kind == KIND_REQUEST) ? S_REQ_CHK : S_REL_CHK;
                end
            end
            S_REQ_CHK: begin
                if (!sts.req_ok)   state_next = S_REPORT;
                else if (sts.afford) state_next = S_SAFE_INIT;
                else               state_next = S_ENQ;
            end
            S_REL_CHK: begin
                if (!sts.rel_ok) begin
                    state_next = S_REPORT;
                end else begin
                    scan_ctx_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SAFE_INIT: state_next = S_SAFE_STEP;
            S_SAFE_STEP: begin
                if (sts.safe_fin) begin
                    if (sts.safe_ok)   state_next = S_GRANT;
                    else if (scan_ctx_reg) state_next = S_SCAN_KEEP;
                    else               state_next = S_ENQ;
                end
            end
            S_GRANT:     state_next = scan_ctx_reg ? S_SCAN_RD : S_REPORT;
            S_ENQ:       state_next = S_REPORT;
            S_SCAN_RD:   state_next = sts.scan_end ? S_REPORT : S_SCAN_LOAD;
            S_SCAN_LOAD: state_next = S_SCAN_CHK;
            S_SCAN_CHK:  state_next = (sts.req_ok && sts.afford) ? S_SAFE_INIT : S_SCAN_KEEP;
            S_SCAN_KEEP: state_next = S_SCAN_RD;
            S_REPORT: begin
                if (sts.out_free && sts.rep_last) state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.row_sel     = ROW_CAND;
        cmd.status_code = STS_GRANTED;
        s_tready        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.row_sel = ROW_IN;
                if (s_tvalid) begin
                    cmd.load_op   = (s_kind inside {KIND_TOTAL, KIND_MAX, KIND_ALLOC});
                    cmd.pend_wr   = vec_kind;
                    cmd.cmd_start = vec_kind && s_last;
                end
            end
            S_REQ_CHK: begin
                if (!sts.req_ok) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STS_EXCEEDS;
                end
            end
            S_REL_CHK: begin
                if (!sts.rel_ok) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STS_REL_INVALID;
                end else begin
                    cmd.rel_apply = 1'b1;
                    cmd.scan_init = 1'b1;
                end
            end
            S_SAFE_INIT: cmd.safe_init = 1'b1;
            S_SAFE_STEP: begin
                cmd.row_sel   = ROW_SAFE;
                cmd.safe_step = 1'b1;
            end
            S_GRANT: begin
                cmd.grant = 1'b1;
                if (scan_ctx_reg) begin
                    cmd.scan_grant = 1'b1;
                end else begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STS_GRANTED;
                end
            end
            S_ENQ: begin
                cmd.set_status = 1'b1;
                if (sts.q_full) begin
                    cmd.status_code = STS_DROPPED;
                end else begin
                    cmd.enq         = 1'b1;
                    cmd.status_code = STS_QUEUED;
                end
            end
            S_SCAN_RD: begin
                if (sts.scan_end) begin
                    cmd.scan_fin    = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STS_RELEASED;
                end else begin
                    cmd.q_rd = 1'b1;
                end
            end
            S_SCAN_LOAD: cmd.cand_from_q = 1'b1;
            S_SCAN_CHK:  ;
            S_SCAN_KEEP: cmd.keep = 1'b1;
            S_REPORT:    cmd.rep_load = sts.out_free;
            default:     ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            scan_ctx_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_ctx_reg <= scan_ctx_next;
        end
    end

endmodule

>>> sv/bankers_resource_allocator.sv
// ----------------------------------------------------------------------------
// bankers_resource_allocator
// Banker's-algorithm allocator with wait queue and full safety sequence.
// ----------------------------------------------------------------------------
// Load words are accepted back to back and give no result. Request/release
// element words are accepted back to back; the word marked last starts the command.
// A command runs its admission check plus the safety walk (one process per cycle,
// at most num_processes passes) per check; a release repeats that for each queue
// entry. Report: num_resources words.
// One command in flight at a time; s_tready is low until the report is queued.
// Reset (aresetn low, synchronous): tables, available vector, queue count
// and control clear; queue storage itself is not cleared.
module bankers_resource_allocator #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // process[2:0], resource[4:3], amount[20:5], zero pad
    input  logic [2:0]  s_tuser,   // kind
    input  logic        s_tlast,   // last element of a request/release vector
    // report words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // resource_index[1:0], available_count[17:2],
                                   // granted_from_queue[22:18], zero pad
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast,   // end_of_report
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bra_pkg::*;

    cmd_t    cmd;
    sts_t    sts;

    logic [3:0]           nproc_reg, nproc_next;
    logic [2:0]           nres_reg,  nres_next;
    logic                 cfg_wr;

    logic [RES_BITS-1:0]  m_res_idx;
    amount_t              m_avail;
    logic [2:0]           m_status;
    logic [4:0]           m_granted;

    // ---- register file: values clamped into the supported range on write ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        nproc_next = nproc_reg;
        nres_next  = nres_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_NUM_PROCS: begin
                    if (pwdata[3:0] == 4'd0)                nproc_next = 4'd1;
                    else if (pwdata[3:0] > 4'(MAX_PROCS))   nproc_next = 4'(MAX_PROCS);
                    else                                    nproc_next = pwdata[3:0];
                end
                REG_NUM_RES: begin
                    if (pwdata[2:0] == 3'd0)                nres_next = 3'd1;
                    else if (pwdata[2:0] > 3'(MAX_RES))     nres_next = 3'(MAX_RES);
                    else                                    nres_next = pwdata[2:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nproc_reg <= 4'(MAX_PROCS);
            nres_reg  <= 3'(MAX_RES);
        end else begin
            nproc_reg <= nproc_next;
            nres_reg  <= nres_next;
        end
    end

    assign prdata = (paddr[2] == REG_NUM_RES) ? {29'd0, nres_reg} : {28'd0, nproc_reg};

    // ---- sequencer ----
    bra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .s_last   (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    // ---- tables, safety walker, queue, report register ----
    bra_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_kind     (s_tuser),
        .s_process  (s_tdata[2:0]),
        .s_resource (s_tdata[4:3]),
        .s_amount   (s_tdata[20:5]),
        .num_procs  (nproc_reg),
        .num_res    (nres_reg),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_res_idx  (m_res_idx),
        .m_avail    (m_avail),
        .m_status   (m_status),
        .m_granted  (m_granted),
        .m_last     (m_tlast)
    );

    assign m_tdata = {1'b0, m_granted, m_avail, m_res_idx};
    assign m_tuser = m_status;

endmodule

>>> sv/bra_checker.sv
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks on the allocator report stream and register port.
// ----------------------------------------------------------------------------
module bra_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast,
    input logic        pready
);
    import bra_pkg::*;

    // stalled report word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("report word changed under stall");

    // queue grants only reported with a release
    a_gfq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STS_RELEASED) |-> (m_tdata[22:18] == 5'd0))
        else $error("granted count on non-release status");

    // status within the defined codes
    a_sts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= STS_REL_INVALID))
        else $error("undefined status code");

    // report words after an accepted non-last word continue the same command
    a_same: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tuser))
        else $error("report broken mid-vector");

    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind bankers_resource_allocator bra_checker u_bra_checker (.*);

>>> test/bankers_resource_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_resource_allocator_test
// Self-checking bench for the banker's allocator: directed table of words,
// then random load/request/release traffic checked against a local predictor,
// under several sender/receiver idling phases and register settings.
// ----------------------------------------------------------------------------
module bankers_resource_allocator_test;
    import bra_pkg::*;

    localparam int QDEPTH = 16;
    localparam logic [15:0] AMAX = 16'hFFFF;

    // one expected report word
    typedef struct packed {
        logic [1:0]  res_idx;
        logic [15:0] avail;
        status_t     sts;
        logic [4:0]  from_q;
        logic        eor;
    } report_t;

    // one row of the directed table; chk set where the first report word is known
    typedef struct {
        kind_t       kind;
        logic [2:0]  proc;
        logic [1:0]  res;
        logic [15:0] amt;
        logic        last;
        logic        chk;
        status_t     sts;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bankers_resource_allocator dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ---- predictor state ----
    logic [15:0] avail_v [MAX_RES];
    logic [15:0] claim_t [MAX_PROCS][MAX_RES];
    logic [15:0] alloc_t [MAX_PROCS][MAX_RES];
    logic [15:0] pend_v  [MAX_RES];
    logic [15:0] wq_amt  [QDEPTH][MAX_RES];
    logic [2:0]  wq_proc [QDEPTH];
    int          wq_cnt;
    int          n_procs, n_res;

    report_t     expected_reports[$];
    int          errors = 0;
    int          send_idle = 0, recv_stall = 0;   // percent
    status_t     last_sts;                        // status of the latest command
    int          n_cmds = 0;

    // request within claim for a process in use
    function automatic bit within_claim(int p, logic [15:0] rq [MAX_RES]);
        if (p >= n_procs) return 0;
        for (int j = 0; j < n_res; j++)
            if (32'(alloc_t[p][j]) + rq[j] > 32'(claim_t[p][j])) return 0;
        return 1;
    endfunction

    function automatic bit can_afford(logic [15:0] rq [MAX_RES]);
        for (int j = 0; j < n_res; j++)
            if (rq[j] > avail_v[j]) return 0;
        return 1;
    endfunction

    // full safety sequence with rq assumed granted to p
    function automatic bit safe_after(int p, logic [15:0] rq [MAX_RES]);
        longint wk [MAX_RES];
        bit     done [MAX_PROCS];
        int     fin = 0;
        bit     moved = 1, ok;
        longint al;
        for (int j = 0; j < n_res; j++) wk[j] = longint'(avail_v[j]) - rq[j];
        for (int i = 0; i < MAX_PROCS; i++) done[i] = 0;
        while (moved) begin
            moved = 0;
            for (int i = 0; i < n_procs; i++) begin
                if (done[i]) continue;
                ok = 1;
                for (int j = 0; j < n_res; j++) begin
                    al = alloc_t[i][j] + ((i == p) ? rq[j] : 0);
                    if (longint'(claim_t[i][j]) > al + wk[j]) ok = 0;
                end
                if (ok) begin
                    for (int j = 0; j < n_res; j++)
                        wk[j] += alloc_t[i][j] + ((i == p) ? rq[j] : 0);
                    done[i] = 1;
                    fin++;
                    moved = 1;
                end
            end
        end
        return fin == n_procs;
    endfunction

    function automatic void hand_out(int p, logic [15:0] rq [MAX_RES]);
        for (int j = 0; j < n_res; j++) begin
            avail_v[j] -= rq[j];
            alloc_t[p][j] += rq[j];
        end
    endfunction

    function automatic void predict_reset();
        for (int j = 0; j < MAX_RES; j++) begin
            avail_v[j] = '0;
            pend_v[j] = '0;
            for (int i = 0; i < MAX_PROCS; i++) begin
                claim_t[i][j] = '0;
                alloc_t[i][j] = '0;
            end
        end
        wq_cnt = 0;
        n_procs = MAX_PROCS;
        n_res = MAX_RES;
    endfunction

    // advance the allocator model by one input word, queueing the report
    function automatic void allocator_step(kind_t k, int p, int r, logic [15:0] amt,
                                           bit last);
        logic [15:0] vec [MAX_RES];
        status_t     st;
        int          ngr = 0, keep = 0;
        longint      a;
        report_t     w;
        if (k > KIND_RELEASE) return;
        if (k == KIND_TOTAL) begin
            avail_v[r] = amt;
            return;
        end
        if (k == KIND_MAX) begin
            claim_t[p][r] = amt;
            return;
        end
        if (k == KIND_ALLOC) begin
            a = longint'(avail_v[r]) + alloc_t[p][r] - amt;
            if (a < 0) a = 0;
            if (a > AMAX) a = AMAX;
            avail_v[r] = 16'(a);
            alloc_t[p][r] = amt;
            return;
        end
        pend_v[r] = amt;
        if (!last) return;
        for (int j = 0; j < MAX_RES; j++) begin
            vec[j] = pend_v[j];
            pend_v[j] = '0;
        end
        if (k == KIND_REQUEST) begin
            if (!within_claim(p, vec)) st = STS_EXCEEDS;
            else if (can_afford(vec) && safe_after(p, vec)) begin
                hand_out(p, vec);
                st = STS_GRANTED;
            end else if (wq_cnt >= QDEPTH) st = STS_DROPPED;
            else begin
                wq_amt[wq_cnt] = vec;
                wq_proc[wq_cnt] = 3'(p);
                wq_cnt++;
                st = STS_QUEUED;
            end
        end else begin
            st = STS_RELEASED;
            if (p >= n_procs) st = STS_REL_INVALID;
            for (int j = 0; j < n_res; j++)
                if (vec[j] > alloc_t[p][j]) st = STS_REL_INVALID;
            if (st == STS_RELEASED) begin
                for (int j = 0; j < n_res; j++) begin
                    a = longint'(avail_v[j]) + vec[j];
                    alloc_t[p][j] -= vec[j];
                    avail_v[j] = (a > AMAX) ? AMAX : 16'(a);
                end
                // single in-order pass; survivors close up
                for (int i = 0; i < wq_cnt; i++) begin
                    if (within_claim(wq_proc[i], wq_amt[i]) && can_afford(wq_amt[i])
                        && safe_after(wq_proc[i], wq_amt[i])) begin
                        hand_out(wq_proc[i], wq_amt[i]);
                        ngr++;
                        continue;
                    end
                    wq_amt[keep] = wq_amt[i];
                    wq_proc[keep] = wq_proc[i];
                    keep++;
                end
                wq_cnt = keep;
            end
        end
        last_sts = st;
        n_cmds++;
        for (int j = 0; j < n_res; j++) begin
            w.res_idx = 2'(j);
            w.avail = avail_v[j];
            w.sts = st;
            w.from_q = 5'(ngr);
            w.eor = (j + 1 == n_res);
            expected_reports = {expected_reports, w};
        end
    endfunction

    // ---- report checker ----
    always @(posedge aclk) begin
        report_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected word %h user %0d last %0b", $time,
                         m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                e = expected_reports.pop_front();
                if (m_tdata[1:0] !== e.res_idx || m_tdata[17:2] !== e.avail
                    || m_tuser !== e.sts || m_tdata[22:18] !== e.from_q
                    || m_tdata[23] !== 1'b0 || m_tlast !== e.eor) begin
                    $display("%0t: expected idx %0d avail %0d sts %0d fromq %0d last %0b",
                             $time, e.res_idx, e.avail, e.sts, e.from_q, e.eor);
                    $display("%0t:   actual idx %0d avail %0d sts %0d fromq %0d last %0b",
                             $time, m_tdata[1:0], m_tdata[17:2], m_tuser,
                             m_tdata[22:18], m_tlast);
                    errors++;
                end
            end
        end
    end

    // receiver stalls, changed at the falling edge
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_stall);

    // ---- driving ----
    // called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so the caller drives the next word or drops it
    task automatic send_word(kind_t k, int p, int r, logic [15:0] amt, bit last);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {3'b000, amt, 2'(r), 3'(p)};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        allocator_step(k, p, r, amt, last);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    // register write while idle; value goes through the same clamp as the block
    task automatic write_reg(logic reg_idx, logic [31:0] val);
        int v;
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {reg_idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (reg_idx == REG_NUM_PROCS) begin
            v = val[3:0];
            n_procs = (v < 1) ? 1 : (v > MAX_PROCS) ? MAX_PROCS : v;
        end else begin
            v = val[2:0];
            n_res = (v < 1) ? 1 : (v > MAX_RES) ? MAX_RES : v;
        end
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    // a whole request/release vector; elements in index order, last carries it
    task automatic send_vector(kind_t k, int p, logic [15:0] v [MAX_RES]);
        for (int j = 0; j < n_res; j++)
            send_word(k, p, j, v[j], j == n_res - 1);
    endtask

    // small random load of totals, claims and allocations
    task automatic random_load(int span);
        for (int j = 0; j < n_res; j++)
            send_word(KIND_TOTAL, 0, j, 16'($urandom_range(span, span * 3)), 0);
        for (int i = 0; i < n_procs; i++)
            for (int j = 0; j < n_res; j++) begin
                send_word(KIND_MAX, i, j, 16'($urandom_range(span)), $urandom_range(1));
                send_word(KIND_ALLOC, i, j, 16'($urandom_range(span / 3)), 0);
            end
    endtask

    // directed rows
    row_t dir_rows [] = '{
        // request before any load: zero claim, zero request fits
        '{KIND_REQUEST, 3'd0, 2'd3, 16'd0,     1'b1, 1'b1, STS_GRANTED},
        // release of nothing from process 7
        '{KIND_RELEASE, 3'd7, 2'd3, 16'd0,     1'b1, 1'b1, STS_RELEASED},
        '{KIND_TOTAL,   3'd7, 2'd0, 16'hFFFF,  1'b1, 1'b0, STS_GRANTED},
        '{KIND_TOTAL,   3'd0, 2'd1, 16'd0,     1'b0, 1'b0, STS_GRANTED},
        '{KIND_TOTAL,   3'd0, 2'd2, 16'd100,   1'b0, 1'b0, STS_GRANTED},
        '{KIND_TOTAL,   3'd0, 2'd3, 16'd100,   1'b0, 1'b0, STS_GRANTED},
        '{KIND_MAX,     3'd7, 2'd3, 16'hFFFF,  1'b0, 1'b0, STS_GRANTED},
        '{KIND_MAX,     3'd2, 2'd2, 16'd50,    1'b0, 1'b0, STS_GRANTED},
        '{KIND_ALLOC,   3'd2, 2'd2, 16'd60,    1'b0, 1'b0, STS_GRANTED}, // negative need
        '{KIND_ALLOC,   3'd1, 2'd1, 16'd5,     1'b0, 1'b0, STS_GRANTED}, // saturates at 0
        // over need
        '{KIND_REQUEST, 3'd0, 2'd0, 16'd1,     1'b1, 1'b1, STS_EXCEEDS},
        '{KIND_REQUEST, 3'd2, 2'd2, 16'd1,     1'b1, 1'b1, STS_EXCEEDS},
        // release beyond allocation
        '{KIND_RELEASE, 3'd1, 2'd1, 16'd6,     1'b1, 1'b1, STS_REL_INVALID},
        // multi-element request, unsent elements zero
        '{KIND_REQUEST, 3'd7, 2'd0, 16'd10,    1'b0, 1'b0, STS_GRANTED},
        '{KIND_REQUEST, 3'd7, 2'd3, 16'd20,    1'b1, 1'b0, STS_GRANTED},
        // unaffordable: queued
        '{KIND_REQUEST, 3'd7, 2'd3, 16'd200,   1'b1, 1'b0, STS_GRANTED},
        '{KIND_RELEASE, 3'd1, 2'd1, 16'd5,     1'b1, 1'b0, STS_GRANTED},
        '{KIND_RELEASE, 3'd7, 2'd3, 16'd20,    1'b1, 1'b0, STS_GRANTED},
        // release beyond the allocation of process 7
        '{KIND_RELEASE, 3'd7, 2'd0, 16'd10,    1'b1, 1'b0, STS_GRANTED},
        // unused kind is ignored
        '{kind_t'(3'd7), 3'd5, 2'd1, 16'hAAAA, 1'b1, 1'b0, STS_GRANTED},
        '{kind_t'(3'd5), 3'd2, 2'd2, 16'h5555, 1'b0, 1'b0, STS_GRANTED}
    };

    initial begin
        logic [15:0] v [MAX_RES];
        int          p, span, nc;
        predict_reset();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        foreach (dir_rows[i]) begin
            nc = n_cmds;
            send_word(dir_rows[i].kind, dir_rows[i].proc, dir_rows[i].res,
                      dir_rows[i].amt, dir_rows[i].last);
            if (dir_rows[i].chk && (n_cmds == nc || last_sts != dir_rows[i].sts)) begin
                $display("%0t: row %0d expected status %0d actual %0d", $time, i,
                         dir_rows[i].sts, last_sts);
                errors++;
            end
        end
        drain();
        write_reg(REG_NUM_PROCS, 32'd1);
        write_reg(REG_NUM_RES, 32'd1);
        send_word(KIND_REQUEST, 3, 0, 16'd0, 1);   // process not in use
        send_word(KIND_RELEASE, 3, 0, 16'd0, 1);
        drain();
        write_reg(REG_NUM_PROCS, 32'hFFFF_FFF0);   // clamps up to 1
        write_reg(REG_NUM_RES, 32'd0);
        send_word(KIND_REQUEST, 0, 0, 16'd0, 1);
        drain();

        // random phases: register setting and idling vary per phase
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_reg(REG_NUM_PROCS, (ph == 0) ? 32'd15 : (ph == 1) ? 32'd1
                                     : $urandom_range(1, 15));
            write_reg(REG_NUM_RES, (ph == 0) ? 32'd7 : (ph == 1) ? 32'd1
                                   : $urandom_range(1, 7));
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 72; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 72; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            span = (ph == 7) ? 65535 : $urandom_range(4, 40);
            random_load(span);
            for (int n = 0; n < ((ph == 1) ? 40 : 8); n++) begin
                p = $urandom_range(n_procs - 1);
                if ($urandom_range(9) == 0) p = $urandom_range(7);
                for (int j = 0; j < MAX_RES; j++)
                    v[j] = (ph == 7 && $urandom_range(3) == 0) ? 16'($urandom)
                         : ($urandom_range(1) ? 16'($urandom_range(span / 2))
                                              : alloc_t[p][j]);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: send_vector(KIND_REQUEST, p, v);
                    5, 6, 7: send_vector(KIND_RELEASE, p, v);
                    8: send_word(kind_t'($urandom_range(2)), $urandom_range(7),
                                 $urandom_range(3), 16'($urandom_range(span)), 0);
                    default: send_word(kind_t'($urandom_range(3, 7)), $urandom_range(7),
                                       $urandom_range(3), 16'($urandom), $urandom_range(1));
                endcase
            end
        end
        send_idle = 0;
        recv_stall = 0;
        drain();
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
sv/bra_pkg.sv
sv/bra_dpath.sv
sv/bra_ctrl.sv
sv/bankers_resource_allocator.sv
sv/bra_checker.sv
test/bankers_resource_allocator_test.sv
